[rtl/mcltm_pkg.sv]
// Shared types and constants for the link timeout monitor.
package mcltm_pkg;

  localparam int FUNC_W      = 2;
  localparam int CHAN_W      = 4;
  localparam int THR_W       = 32;
  localparam int MASK_W      = 16;
  localparam int PERIOD_W    = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam int DEF_CHANNELS   = 16;
  localparam int DEF_COUNT_BITS = 32;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 16'd1;

  // register indexes
  localparam logic REG_TICK_PERIOD = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 2'd0,
    FN_ARM    = 2'd1,
    FN_FEED   = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

[rtl/mcltm_if.sv]
// Request and response channel interfaces.
interface mcltm_req_if
  import mcltm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAN_W-1:0] channel;
  logic [THR_W-1:0]  threshold_ms;

  modport source (output valid, func, channel, threshold_ms, input ready);
  modport sink   (input valid, func, channel, threshold_ms, output ready);
endinterface

interface mcltm_rsp_if
  import mcltm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] lost_mask;
  logic              ok;

  modport source (output valid, lost_mask, ok, input ready);
  modport sink   (input valid, lost_mask, ok, output ready);
endinterface

[rtl/mcltm_sat_cmp.sv]
// Shared saturating add and threshold compare used by the tick sweep.
module mcltm_sat_cmp
  import mcltm_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic [COUNT_BITS-1:0] elapsed,
  input  logic [THR_W-1:0]      limit,
  input  logic [PERIOD_W-1:0]   period,
  output logic [COUNT_BITS-1:0] sum,
  output logic                  reached
);

  localparam int SW = ((COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W) + 1;
  localparam int CW = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  logic [SW-1:0] raw;
  logic          over;

  always_comb begin
    raw     = SW'(elapsed) + SW'(period);
    over    = raw > SW'({COUNT_BITS{1'b1}});
    sum     = over ? {COUNT_BITS{1'b1}} : raw[COUNT_BITS-1:0];
    reached = CW'(sum) >= CW'(limit);
  end

endmodule

[rtl/multi_channel_link_timeout_monitor.sv]
// Top level: multi-channel link timeout monitor (channel table and sequencer).
// Sequence: arm, feed and remove pass through the OP and EMIT states from accept
//   to result; a tick passes through SWEEP, DRAIN and EMIT, where one shared
//   add/compare unit sweeps the counter and threshold memories, one channel per cycle.
// Flow: one request at a time; a new request is accepted only in the idle
//   state. A result left waiting stalls only the next result, not the accept of the
//   next request.
// Reset (rst, synchronous, active high): all channels inactive, no lost flags,
//   tick_period = 1. The memories need no clearing: entries are read only for
//   active channels, and arming writes both counter and threshold.
module multi_channel_link_timeout_monitor
  import mcltm_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  mcltm_req_if.sink             req,
  mcltm_rsp_if.source           rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW  = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam logic [CIW-1:0] LAST_IDX = CIW'(CHANNELS - 1);

  // ---------------------------------------------------------------- config
  logic [PERIOD_W-1:0] tick_period;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RST;
    end else if (cfg_wr && (paddr[2] == REG_TICK_PERIOD)) begin
      tick_period <= pwdata[PERIOD_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TICK_PERIOD) ? APB_DATA_W'(tick_period) : '0;

  // ---------------------------------------------------------------- state
  state_t state, state_next;

  func_t             op_func;
  logic [CHAN_W-1:0] op_chan;
  logic [THR_W-1:0]  op_thr;
  logic              op_ok;

  logic [CHANNELS-1:0] active;     // per-channel active mark (acts as valid bit)
  logic [CHANNELS-1:0] lost;       // per-channel lost flag

  // counter / threshold memories: one write and one registered read per cycle
  logic [COUNT_BITS-1:0] elapsed_mem [CHANNELS];
  logic [THR_W-1:0]      limit_mem   [CHANNELS];
  logic [COUNT_BITS-1:0] rd_elapsed;
  logic [THR_W-1:0]      rd_limit;

  logic [CIW-1:0] rd_idx;      // sweep read pointer
  logic [CIW-1:0] wb_idx;      // sweep write-back pointer (one behind)
  logic           wb_vld;

  logic req_acc;
  logic in_range;
  logic [CIW-1:0] op_idx;
  logic op_active;

  // control from the output decode
  logic                  el_we, lim_we;
  logic [CIW-1:0]        el_addr, lim_addr;
  logic [COUNT_BITS-1:0] el_wdata;
  logic [THR_W-1:0]      lim_wdata;
  logic                  act_set, act_clr, lost_clr, lost_set;
  logic                  ok_calc;
  logic                  sweep_rd;
  logic                  out_load;

  logic [COUNT_BITS-1:0] sat_sum;
  logic                  sat_reached;

  assign req_acc   = req.valid && req.ready;
  assign in_range  = 32'(op_chan) < CHANNELS;
  assign op_idx    = CIW'(op_chan);
  assign op_active = in_range && active[op_idx];

  mcltm_sat_cmp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_sat_cmp (
    .elapsed (rd_elapsed),
    .limit   (rd_limit),
    .period  (tick_period),
    .sum     (sat_sum),
    .reached (sat_reached)
  );

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          state_next = (func_t'(req.func) == FN_TICK) ? ST_SWEEP : ST_OP;
        end
      end
      ST_OP:    state_next = ST_EMIT;
      ST_SWEEP: begin
        if (rd_idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    el_we     = 1'b0;
    lim_we    = 1'b0;
    el_addr   = op_idx;
    lim_addr  = op_idx;
    el_wdata  = '0;
    lim_wdata = '0;
    act_set   = 1'b0;
    act_clr   = 1'b0;
    lost_clr  = 1'b0;
    lost_set  = 1'b0;
    ok_calc   = 1'b1;
    sweep_rd  = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_OP: begin
        if (!in_range) begin
          ok_calc = 1'b0;
        end else begin
          priority case (op_func)
            FN_ARM: begin
              el_we     = 1'b1;
              lim_we    = 1'b1;
              lim_wdata = op_thr;
              act_set   = 1'b1;
              lost_clr  = 1'b1;
            end
            FN_FEED: begin
              ok_calc  = op_active;
              el_we    = op_active;
              lost_clr = op_active;
            end
            FN_REMOVE: begin
              ok_calc  = op_active;
              el_we    = op_active;
              lim_we   = op_active;
              act_clr  = op_active;
              lost_clr = op_active;
            end
            default: ok_calc = 1'b1;
          endcase
        end
      end
      ST_SWEEP, ST_DRAIN: begin
        sweep_rd = (state == ST_SWEEP);
        el_addr  = wb_idx;
        el_wdata = sat_sum;
        if (wb_vld && active[wb_idx]) begin
          el_we    = 1'b1;
          lost_set = sat_reached;
        end
      end
      ST_EMIT: out_load = !rsp.valid || rsp.ready;
      default: req.ready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      wb_vld <= 1'b0;
      active <= '0;
      lost   <= '0;
    end else begin
      state  <= state_next;
      wb_vld <= sweep_rd;
      if (act_set) active[op_idx] <= 1'b1;
      if (act_clr) active[op_idx] <= 1'b0;
      if (lost_clr) lost[op_idx] <= 1'b0;
      if (lost_set) lost[wb_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      op_func <= func_t'(req.func);
      op_chan <= req.channel;
      op_thr  <= req.threshold_ms;
      op_ok   <= 1'b1;
      rd_idx  <= '0;
    end else begin
      if (state == ST_OP) op_ok <= ok_calc;
      if (sweep_rd) rd_idx <= rd_idx + 1'b1;
    end
    wb_idx <= rd_idx;
  end

  // memories
  always_ff @(posedge clk) begin
    if (el_we) elapsed_mem[el_addr] <= el_wdata;
    if (lim_we) limit_mem[lim_addr] <= lim_wdata;
    rd_elapsed <= elapsed_mem[rd_idx];
    rd_limit   <= limit_mem[rd_idx];
  end

  // output register: lost mask is taken after the request has fully landed
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.lost_mask <= MASK_W'(active[MW-1:0] & lost[MW-1:0]);
      rsp.ok        <= op_ok;
    end
  end

`ifndef NO_ASSERTIONS
  a_lost_only_active: assert property (@(posedge clk) disable iff (rst)
    (lost & ~active) == '0)
    else $error("lost flag set on inactive channel");

  a_wb_in_sweep: assert property (@(posedge clk) disable iff (rst)
    wb_vld |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("write-back outside sweep");

  a_drain_to_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |=> state == ST_EMIT)
    else $error("sweep did not finish into emit");

  a_tick_arm_ok: assert property (@(posedge clk) disable iff (rst)
    (out_load && (op_func == FN_TICK || op_func == FN_ARM) && in_range) |-> op_ok)
    else $error("tick or arm reported failure");
`endif

endmodule
